// File: rtl/lbrg_pkg.sv
`timescale 1ns / 1ps

package lbrg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned CMD_W  = 2;

    // Generator constants: seed = seed * LCG_MUL + LCG_INC, modulo 2^32.
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [WORD_W-1:0] LCG_INC = 32'd2531011;

    localparam logic [CMD_W-1:0] CMD_DRAW_U    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW_S    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_SEED = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP       = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_HI,
        ST_ADD_HI,
        ST_MUL_LO,
        ST_ADD_LO,
        ST_TEST,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seed;
        logic capture;
        logic clear_draw;
        logic mul;
        logic add_hi;
        logic add_lo;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic span_zero;
        logic reject;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/lcg_bounded_random_generator.sv
`timescale 1ns / 1ps

// Bounded random number generator on a 32-bit linear congruential seed
// (seed * 214013 + 2531011). Command 0 returns a word in range_min..range_max
// (span taken modulo 2^32), command 1 a signed word between 0 and range_max,
// command 2 loads the seed and returns nothing, command 3 does nothing. Draws
// above the span are rejected and drawn again. Each generator step goes through
// the constant multiplier and then the adder, and a 32-bit draw needs two steps
// plus a compare. A range request stalls the input through all of its draw
// attempts (under two on average) until its result is taken into the output
// register; an empty span skips the attempts. Seed loads and no-ops do not
// stall the input. The result waits in an output register, so the next word
// can be accepted while it is still stalled.
module lcg_bounded_random_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lbrg_pkg::CMD_W-1:0]  command,
    input  logic [lbrg_pkg::WORD_W-1:0] range_min,
    input  logic [lbrg_pkg::WORD_W-1:0] range_max,
    input  logic [lbrg_pkg::WORD_W-1:0] seed_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lbrg_pkg::WORD_W-1:0] random_value
);
    import lbrg_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    lbrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    lbrg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .command      (command),
        .range_min    (range_min),
        .range_max    (range_max),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

endmodule

// File: rtl/lbrg_ctrl.sv
`timescale 1ns / 1ps

module lbrg_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [lbrg_pkg::CMD_W-1:0] command,
    input  lbrg_pkg::dp_status_t      status,
    output lbrg_pkg::dp_cmd_t         cmd
);
    import lbrg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_DRAW_U || command == CMD_DRAW_S))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = status.span_zero ? ST_FINISH : ST_MUL_HI;
            end
            ST_MUL_HI: state_next = ST_ADD_HI;
            ST_ADD_HI: state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_ADD_LO;
            ST_ADD_LO: state_next = ST_TEST;
            ST_TEST:
            begin
                state_next = status.reject ? ST_MUL_HI : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_seed = accept && (command == CMD_LOAD_SEED);
                cmd.capture   = accept && (command == CMD_DRAW_U || command == CMD_DRAW_S);
            end
            ST_START:  cmd.clear_draw = status.span_zero;
            ST_MUL_HI: cmd.mul        = 1'b1;
            ST_ADD_HI: cmd.add_hi     = 1'b1;
            ST_MUL_LO: cmd.mul        = 1'b1;
            ST_ADD_LO: cmd.add_lo     = 1'b1;
            ST_TEST:   cmd            = '0;
            ST_FINISH: cmd.emit       = !status.out_busy;
            default:   cmd            = '0;
        endcase
    end

endmodule

// File: rtl/lbrg_dp.sv
`timescale 1ns / 1ps

module lbrg_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lbrg_pkg::dp_cmd_t           cmd,
    output lbrg_pkg::dp_status_t        status,
    input  logic [lbrg_pkg::CMD_W-1:0]  command,
    input  logic [lbrg_pkg::WORD_W-1:0] range_min,
    input  logic [lbrg_pkg::WORD_W-1:0] range_max,
    input  logic [lbrg_pkg::WORD_W-1:0] seed_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lbrg_pkg::WORD_W-1:0] random_value
);
    import lbrg_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] seed_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] span_next;
    logic [WORD_W-1:0] base_reg;
    logic              neg_reg;
    logic [HALF_W-1:0] hi_reg;
    logic [WORD_W-1:0] draw_reg;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] result_next;
    logic              out_valid_reg;

    // Smallest all-ones mask that covers the span.
    always_comb
    begin
        mask = span_reg;
        mask = mask | (mask >> 1);
        mask = mask | (mask >> 2);
        mask = mask | (mask >> 4);
        mask = mask | (mask >> 8);
        mask = mask | (mask >> 16);
    end

    assign seed_next = prod_reg + LCG_INC;

    always_comb
    begin
        if (command == CMD_DRAW_S)
        begin
            span_next = range_max[WORD_W-1] ? (WORD_W'(0) - range_max) : range_max;
        end
        else
        begin
            span_next = range_max - range_min;
        end
    end

    assign result_next = neg_reg ? (WORD_W'(0) - draw_reg) : (draw_reg + base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cmd.load_seed)
        begin
            seed_reg <= seed_value;
        end
        else if (cmd.add_hi || cmd.add_lo)
        begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= seed_reg * LCG_MUL;
        end
        if (cmd.capture)
        begin
            span_reg <= span_next;
            base_reg <= (command == CMD_DRAW_S) ? '0 : range_min;
            neg_reg  <= (command == CMD_DRAW_S) && range_max[WORD_W-1];
        end
        if (cmd.add_hi)
        begin
            hi_reg <= seed_next[WORD_W-1:HALF_W];
        end
        if (cmd.clear_draw)
        begin
            draw_reg <= '0;
        end
        else if (cmd.add_lo)
        begin
            draw_reg <= {hi_reg, seed_next[WORD_W-1:HALF_W]} & mask;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.span_zero = (span_reg == '0);
    assign status.reject    = (draw_reg > span_reg);
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign random_value = result_reg;

endmodule
